[rtl/slot_table_nearest_free_assert.svh]
// Assertion macros for the slot table block.
// Included by the modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef SLOT_TABLE_NEAREST_FREE_ASSERT_SVH
`define SLOT_TABLE_NEAREST_FREE_ASSERT_SVH
`ifndef SYNTHESIS
`define SLT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SLT_ASSERT_NEXT(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);
`else
`define SLT_ASSERT(lbl, prop, msg)
`define SLT_ASSERT_NEXT(lbl, cond, conseq, msg)
`endif
`endif

[rtl/slt_pkg.sv]
// Shared constants, codes and types for the slot table block.
// No dependencies; imported by every module of the block.
package slt_pkg;

    localparam int SLOTS  = 8;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int POS_W  = 6;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 7;
    localparam int STAT_W = 3;
    localparam int CMD_W  = 2;

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_BADPOS   = 3'd2,
        STAT_NOTFOUND = 3'd3,
        STAT_EMPTY    = 3'd4,
        STAT_ZERO     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_SEARCH
    } ctrl_state_t;

    // one request to the slot memory per cycle
    typedef struct packed {
        logic             wr_en;    // store word and mark slot taken
        logic             clr_en;   // mark slot empty
        idx_t             addr;
        logic [VAL_W-1:0] wr_data;
        logic             rd_en;
        idx_t             rd_addr;
    } mem_req_t;

    typedef struct packed {
        status_t          status;
        logic [POS_W-1:0] slot_index;
        logic [CNT_W-1:0] count;
    } result_t;

endpackage

[rtl/slt_mem.sv]
// Slot word memory with registered read, plus per-slot occupancy flags.
// Depends on slt_pkg. An empty slot reads as zero.
module slt_mem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  slt_pkg::mem_req_t             req,
    output logic [slt_pkg::SLOTS-1:0]     valid,
    output logic [slt_pkg::VAL_W-1:0]     rd_data
);
    import slt_pkg::*;

    logic [VAL_W-1:0] mem [SLOTS];
    logic [VAL_W-1:0] rd_q_reg;
    logic             rd_valid_reg;
    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] valid_next;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_q_reg <= mem[req.rd_addr];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (req.wr_en)
        begin
            valid_next[req.addr] = 1'b1;
        end
        if (req.clr_en)
        begin
            valid_next[req.addr] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign valid   = valid_reg;
    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

[rtl/slt_ctrl.sv]
// Command sequencer: decodes commands, walks for the nearest free slot, scans on search,
// keeps the occupied count and holds the result register. Depends on slt_pkg.
`include "slot_table_nearest_free_assert.svh"
module slt_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [slt_pkg::CMD_W-1:0]     cmd,
    input  logic [slt_pkg::POS_W-1:0]     pos,
    input  logic [slt_pkg::VAL_W-1:0]     value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output slt_pkg::result_t              out_res,
    output slt_pkg::mem_req_t             mem_req,
    input  logic [slt_pkg::SLOTS-1:0]     valid,
    input  logic [slt_pkg::VAL_W-1:0]     rd_data
);
    import slt_pkg::*;

    ctrl_state_t      state_reg, state_next;
    idx_t             pos_reg, pos_next;
    idx_t             dist_reg, dist_next;
    idx_t             cmp_idx_reg, cmp_idx_next;
    logic [VAL_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             res_valid_reg;
    result_t          res_reg;
    result_t          res_new;
    logic             done;

    logic             take;
    logic             out_free;
    logic             pos_ok;
    idx_t             pos_idx;
    logic             tbl_full;
    logic             walk_start;
    logic             search_start;
    idx_t             left_idx;
    logic [IDX_W:0]   right_sum;
    logic             left_ok;
    logic             right_ok;

    // decode and walk candidates
    always_comb
    begin
        out_free     = !res_valid_reg || out_ready;
        in_ready     = (state_reg == S_IDLE) && out_free;
        take         = in_valid && in_ready;
        pos_ok       = {1'b0, pos} < (POS_W+1)'(SLOTS);
        pos_idx      = pos[IDX_W-1:0];
        tbl_full     = count_reg >= CNT_W'(SLOTS);
        walk_start   = take && (cmd_t'(cmd) == CMD_INSERT) && !tbl_full && pos_ok
                       && (value != '0) && valid[pos_idx];
        search_start = take && (cmd_t'(cmd) == CMD_SEARCH);
        left_idx     = pos_reg - dist_reg;
        right_sum    = {1'b0, pos_reg} + {1'b0, dist_reg};
        left_ok      = (dist_reg <= pos_reg) ? !valid[left_idx] : 1'b0;
        right_ok     = (right_sum < (IDX_W+1)'(SLOTS)) ? !valid[right_sum[IDX_W-1:0]] : 1'b0;
    end

    // outputs: memory request, result and count update
    always_comb
    begin
        done               = 1'b0;
        mem_req            = '0;
        count_next         = count_reg;
        res_new.status     = STAT_OK;
        res_new.slot_index = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    unique case (cmd_t'(cmd))
                        CMD_INSERT:
                        begin
                            done = !walk_start;
                            if (tbl_full)
                            begin
                                res_new.status = STAT_FULL;
                            end
                            else if (!pos_ok)
                            begin
                                res_new.status = STAT_BADPOS;
                            end
                            else if (value == '0)
                            begin
                                res_new.status = STAT_ZERO;
                            end
                            else if (!valid[pos_idx])
                            begin
                                mem_req.wr_en      = 1'b1;
                                mem_req.addr       = pos_idx;
                                mem_req.wr_data    = value;
                                count_next         = count_reg + CNT_W'(1);
                                res_new.slot_index = POS_W'(pos_idx);
                            end
                        end
                        CMD_REMOVE:
                        begin
                            done = 1'b1;
                            if (!pos_ok)
                            begin
                                res_new.status = STAT_BADPOS;
                            end
                            else if (!valid[pos_idx])
                            begin
                                res_new.status = STAT_EMPTY;
                            end
                            else
                            begin
                                mem_req.clr_en     = 1'b1;
                                mem_req.addr       = pos_idx;
                                res_new.slot_index = POS_W'(pos_idx);
                                if (count_reg != '0)
                                begin
                                    count_next = count_reg - CNT_W'(1);
                                end
                            end
                        end
                        CMD_SEARCH:
                        begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = idx_t'(SLOTS - 1);
                        end
                        default:
                        begin
                            done           = 1'b1;
                            res_new.status = STAT_BADPOS;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (out_free)
                begin
                    // left side first at each distance
                    if (left_ok)
                    begin
                        done               = 1'b1;
                        mem_req.wr_en      = 1'b1;
                        mem_req.addr       = left_idx;
                        mem_req.wr_data    = key_reg;
                        count_next         = count_reg + CNT_W'(1);
                        res_new.slot_index = POS_W'(left_idx);
                    end
                    else if (right_ok)
                    begin
                        done               = 1'b1;
                        mem_req.wr_en      = 1'b1;
                        mem_req.addr       = right_sum[IDX_W-1:0];
                        mem_req.wr_data    = key_reg;
                        count_next         = count_reg + CNT_W'(1);
                        res_new.slot_index = POS_W'(right_sum[IDX_W-1:0]);
                    end
                    else if (dist_reg == idx_t'(SLOTS - 1))
                    begin
                        done           = 1'b1;
                        res_new.status = STAT_FULL;
                    end
                end
            end
            S_SEARCH:
            begin
                if (out_free)
                begin
                    if (rd_data == key_reg)
                    begin
                        done               = 1'b1;
                        res_new.slot_index = POS_W'(cmp_idx_reg);
                    end
                    else if (cmp_idx_reg == '0)
                    begin
                        done           = 1'b1;
                        res_new.status = STAT_NOTFOUND;
                    end
                    else
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = cmp_idx_reg - idx_t'(1);
                    end
                end
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
        res_new.count = count_next;
    end

    // next state
    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        dist_next    = dist_reg;
        cmp_idx_next = cmp_idx_reg;
        key_next     = key_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (walk_start)
                begin
                    state_next = S_WALK;
                    pos_next   = pos_idx;
                    dist_next  = idx_t'(1);
                    key_next   = value;
                end
                else if (search_start)
                begin
                    state_next   = S_SEARCH;
                    cmp_idx_next = idx_t'(SLOTS - 1);
                    key_next     = value;
                end
            end
            S_WALK:
            begin
                if (done)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    dist_next = dist_reg + idx_t'(1);
                end
            end
            S_SEARCH:
            begin
                if (done)
                begin
                    state_next = S_IDLE;
                end
                else if (mem_req.rd_en)
                begin
                    cmp_idx_next = mem_req.rd_addr;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (done)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        dist_reg    <= dist_next;
        cmp_idx_reg <= cmp_idx_next;
        key_reg     <= key_next;
        if (done)
        begin
            res_reg <= res_new;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_res   = res_reg;

    `SLT_ASSERT(a_count_range, count_reg <= CNT_W'(SLOTS), "occupied count above table size")
    `SLT_ASSERT(a_count_flags, CNT_W'($countones(valid)) == count_reg, "count differs from flags")
    `SLT_ASSERT(a_write_has_result, mem_req.wr_en |-> done, "slot written without a result")
    `SLT_ASSERT(a_walk_taken, (state_reg == S_WALK) |-> valid[pos_reg], "walk from empty slot")
    `SLT_ASSERT_NEXT(a_write_marks, mem_req.wr_en, valid[$past(mem_req.addr)], "slot not marked")

endmodule

[rtl/slot_table_nearest_free.sv]
// Slot table, nearest-free insert: top level with stream ports.
// Depends on slt_pkg, slt_mem and slt_ctrl.
//
// Usage:
//   Commands arrive on the s_* channel, one transfer per command; each gives exactly
//   one result transfer on the m_* channel.
//   Remove, refused commands and an insert whose requested slot is free finish in the
//   accept cycle; the result is registered and shown the next cycle.
//   An insert that finds its slot taken walks outwards one distance per cycle
//   (left before right), up to distance SLOTS-1, from the occupancy flags.
//   A search reads the slot memory one entry per cycle from the top index down;
//   its registered read port sets the pace.
//   One command is worked at a time; the next is accepted once the result register
//   is free or being emptied in the same cycle.
//   Reset clears every occupancy flag and the count at once: no clearing pass.
//   When the receiver stalls, the result holds on m_tdata and s_tready stays low.
module slot_table_nearest_free (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position[5:0], value[37:6], zero pad
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[2:0], slot_index[8:3], occupied_count[15:9]
);
    import slt_pkg::*;

    mem_req_t         mem_req;
    logic [SLOTS-1:0] valid;
    logic [VAL_W-1:0] rd_data;
    result_t          res;

    slt_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .valid   (valid),
        .rd_data (rd_data)
    );

    slt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .cmd       (s_tuser),
        .pos       (s_tdata[5:0]),
        .value     (s_tdata[37:6]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res),
        .mem_req   (mem_req),
        .valid     (valid),
        .rd_data   (rd_data)
    );

    assign m_tdata = {res.count, res.slot_index, res.status};

endmodule

[tb/slot_table_nearest_free_tb.sv]
// Self-checking testbench for slot_table_nearest_free: directed and random commands.
// A shadow slot table predicts every result; depends on slt_pkg and the RTL only.
`timescale 1ns / 1ps

module slot_table_nearest_free_tb;
    import slt_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 2000;
    localparam int HOLD_START   = 3000;   // receiver cycle at which the long hold begins
    localparam int HOLD_LEN     = 400;
    localparam int DRAIN_CYCLES = 4 * SLOTS + 16;
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct {
        logic [CMD_W-1:0]        cmd;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] value;
        bit                      drain_first;  // wait for every result before offering
    } table_cmd_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [39:0] s_tdata = '0;   // position[5:0], value[37:6], zero pad
    logic [1:0] s_tuser = '0;    // command[1:0]
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [15:0] m_tdata;        // status[2:0], slot_index[8:3], occupied_count[15:9]

    table_cmd_t pending_cmds[$];
    result_t    expected_results[$];
    table_cmd_t cur_cmd;
    bit         offer;
    int         gap_left;
    int         burst_left;
    int         rx_cycle;
    int         stall_pct;
    int         cycle_count = 0;
    int         fail_count = 0;

    // shadow copy of the table
    logic [VAL_W-1:0] shadow_slots[SLOTS];
    int               shadow_used;

    slot_table_nearest_free u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic result_t predict_table_result(table_cmd_t c);
        result_t r;
        int p;
        int d;
        int hit;
        r.status = STAT_OK;
        r.slot_index = '0;
        p = c.pos;
        hit = -1;
        case (c.cmd)
            CMD_INSERT:
            begin
                if (shadow_used >= SLOTS)
                    r.status = STAT_FULL;
                else if (p >= SLOTS)
                    r.status = STAT_BADPOS;
                else if (c.value == 0)
                    r.status = STAT_ZERO;
                else
                begin
                    // nearest empty slot, left before right at each distance
                    for (d = 0; d < SLOTS && hit < 0; d++)
                    begin
                        if (d <= p && shadow_slots[p-d] == '0)
                            hit = p - d;
                        else if (d > 0 && p + d < SLOTS && shadow_slots[p+d] == '0)
                            hit = p + d;
                    end
                    if (hit >= 0)
                    begin
                        shadow_slots[hit] = c.value;
                        shadow_used++;
                        r.slot_index = POS_W'(hit);
                    end
                    else
                        r.status = STAT_FULL;
                end
            end
            CMD_REMOVE:
            begin
                if (p >= SLOTS)
                    r.status = STAT_BADPOS;
                else if (shadow_slots[p] == '0)
                    r.status = STAT_EMPTY;
                else
                begin
                    shadow_slots[p] = '0;
                    if (shadow_used > 0)
                        shadow_used--;
                    r.slot_index = POS_W'(p);
                end
            end
            CMD_SEARCH:
            begin
                for (d = SLOTS - 1; d >= 0 && hit < 0; d--)
                    if (shadow_slots[d] == c.value)
                        hit = d;
                if (hit >= 0)
                    r.slot_index = POS_W'(hit);
                else
                    r.status = STAT_NOTFOUND;
            end
            default:
                r.status = STAT_BADPOS;
        endcase
        r.count = CNT_W'(shadow_used);
        return r;
    endfunction

    task automatic queue_cmd(logic [CMD_W-1:0] cmd, int pos, logic [VAL_W-1:0] value,
                             bit drain_first = 1'b0);
        table_cmd_t c;
        c.cmd = cmd;
        c.pos = POS_W'(pos);
        c.value = value;
        c.drain_first = drain_first;
        pending_cmds.push_back(c);
    endtask

    // sender: bursts of transfers separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            offer = 1'b0;
            gap_left = 0;
            burst_left = 1;
            for (int i = 0; i < SLOTS; i++)
                shadow_slots[i] = '0;
            shadow_used = 0;
        end
        else
        begin
            if (offer && s_tready)
            begin
                expected_results.push_back(predict_table_result(cur_cmd));
                offer = 1'b0;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            if (!offer)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_cmds.size() > 0 &&
                         !(pending_cmds[0].drain_first && expected_results.size() > 0))
                begin
                    cur_cmd = pending_cmds.pop_front();
                    offer = 1'b1;
                    s_tdata <= {2'b00, cur_cmd.value, cur_cmd.pos};
                    s_tuser <= cur_cmd.cmd;
                end
            end
            s_tvalid <= offer;
        end
    end

    // receiver: checks each transfer, stalls on a random pattern that changes over the run
    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_cycle = 0;
            stall_pct = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: m_tdata=%h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (m_tdata[2:0] !== exp_r.status)
                    begin
                        $error("status: expected %0d, actual %0d", exp_r.status, m_tdata[2:0]);
                        fail_count++;
                    end
                    if (m_tdata[8:3] !== exp_r.slot_index)
                    begin
                        $error("slot_index: expected %0d, actual %0d",
                               exp_r.slot_index, m_tdata[8:3]);
                        fail_count++;
                    end
                    if (m_tdata[15:9] !== exp_r.count)
                    begin
                        $error("occupied_count: expected %0d, actual %0d",
                               exp_r.count, m_tdata[15:9]);
                        fail_count++;
                    end
                end
            end
            rx_cycle++;
            if (rx_cycle % 64 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    default: stall_pct = 60;
                endcase
            end
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
                m_tready <= 1'b0;
            else
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [VAL_W-1:0] value_pool[12];
        int ins_pct;
        int k;
        int p;
        logic [CMD_W-1:0] c;
        logic [VAL_W-1:0] v;

        // directed: refusals on an empty table, collisions, full table, zero key
        queue_cmd(CMD_SEARCH, 0, 32'd0);
        queue_cmd(CMD_REMOVE, 3, 32'd0);
        queue_cmd(CMD_INSERT, 0, 32'd0);
        queue_cmd(CMD_INSERT, 63, 32'd5);
        queue_cmd(CMD_INSERT, SLOTS, 32'd5);
        queue_cmd(CMD_REMOVE, 63, 32'hFFFF_FFFF);
        queue_cmd(CMD_UNUSED, 2, 32'd1);
        queue_cmd(CMD_INSERT, 0, 32'hFFFF_FFFF);
        queue_cmd(CMD_INSERT, 0, 32'h8000_0000);
        queue_cmd(CMD_INSERT, SLOTS - 1, 32'h7FFF_FFFF);
        queue_cmd(CMD_INSERT, SLOTS - 1, 32'd42);
        queue_cmd(CMD_INSERT, 3, 32'd42);
        queue_cmd(CMD_INSERT, 3, 32'd17);
        queue_cmd(CMD_INSERT, 3, 32'd99);
        queue_cmd(CMD_SEARCH, 0, 32'd42);
        queue_cmd(CMD_SEARCH, 63, 32'hFFFF_FFFF);
        queue_cmd(CMD_SEARCH, 0, 32'd12345);
        queue_cmd(CMD_INSERT, 5, 32'd7);
        queue_cmd(CMD_INSERT, 2, 32'd9);
        queue_cmd(CMD_INSERT, 63, 32'd0);
        queue_cmd(CMD_SEARCH, 0, 32'd0);
        queue_cmd(CMD_REMOVE, 0, 32'd0);
        queue_cmd(CMD_SEARCH, 0, 32'd0);
        queue_cmd(CMD_INSERT, 63, 32'd0);
        queue_cmd(CMD_REMOVE, 0, 32'd0);

        value_pool[0] = 32'hFFFF_FFFF;
        value_pool[1] = 32'h8000_0000;
        value_pool[2] = 32'h7FFF_FFFF;
        value_pool[3] = 32'd1;
        for (int i = 4; i < 12; i++)
            value_pool[i] = $urandom;

        // random: phases lean towards filling or emptying the table
        ins_pct = 50;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 50 == 0)
                ins_pct = $urandom_range(15, 85);
            k = $urandom_range(0, 99);
            if (k < 3)
                c = CMD_UNUSED;
            else
            begin
                k = $urandom_range(0, 99);
                if (k < ins_pct)
                    c = CMD_INSERT;
                else if (k < ins_pct + (100 - ins_pct) / 2)
                    c = CMD_REMOVE;
                else
                    c = CMD_SEARCH;
            end
            p = ($urandom_range(0, 99) < 85) ? $urandom_range(0, SLOTS - 1)
                                              : $urandom_range(0, 63);
            k = $urandom_range(0, 99);
            if (k < 80)
                v = value_pool[$urandom_range(0, 11)];
            else if (k < 85)
                v = '0;
            else
                v = $urandom;
            // the first random transfer and one midway wait for the table to go quiet
            queue_cmd(c, p, v, (i == 0) || (i == RANDOM_ITEMS / 2));
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (pending_cmds.size() > 0 || offer || expected_results.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[slot_table_nearest_free.f]
+incdir+rtl
rtl/slt_pkg.sv
rtl/slt_mem.sv
rtl/slt_ctrl.sv
rtl/slot_table_nearest_free.sv
tb/slot_table_nearest_free_tb.sv
